@@ src/lfs_pkg.sv @@
`timescale 1ns / 1ps
// lfs_pkg: constants, types and helper functions for the line follow steering block.
// No dependencies; used by the channel interfaces and the top level.
package lfs_pkg;

    // History store geometry
    localparam int HIST_DEPTH = 100;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W      = $clog2(HIST_DEPTH * (HIST_DEPTH + 1) / 2 + 1);

    // Field and register widths
    localparam int SENS_W     = 5;
    localparam int KP_W       = 6;
    localparam int BASE_W     = 7;
    localparam int THR_W      = 16;
    localparam int SPD_W      = 11;
    localparam int TRK_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;

    // Steering arithmetic widths
    localparam int WGT_W   = 5;   // signed weight, -9..9
    localparam int INFL_W  = 4;   // influence, 0..9
    localparam int BI_W    = 11;  // base * influence
    localparam int STEER_W = 12;  // signed 2 * kp * weight
    localparam int NUM_W   = 12;  // dividend magnitude
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 2'd3;

    // Register reset values
    localparam logic [KP_W-1:0]   KP_RST    = 6'd19;
    localparam logic [BASE_W-1:0] BASE_RST  = 7'd60;
    localparam logic [THR_W-1:0]  THR_RST   = 16'd400;
    localparam logic              WHITE_RST = 1'b1;

    // Tracking codes
    localparam logic [TRK_W-1:0] TRK_CENTERED   = 2'd0;
    localparam logic [TRK_W-1:0] TRK_LOST_LEFT  = 2'd1;
    localparam logic [TRK_W-1:0] TRK_LOST_RIGHT = 2'd2;

    // Lost-line steering
    localparam logic signed [WGT_W-1:0] LOST_WGT  = 5'sd9;
    localparam logic [INFL_W-1:0]       LOST_INFL = 4'd2;

    typedef logic [SENS_W-1:0] t_sens;
    typedef logic [TRK_W-1:0]  t_trk;
    typedef logic signed [SPD_W-1:0] t_speed;

    // Weight over set sensors: far left -3, left -1, centre 0, right +1, far right +3
    function automatic logic signed [WGT_W-1:0] sens_weight(input t_sens b);
        logic signed [WGT_W-1:0] w;
        begin
            w = '0;
            if (b[4]) w = w - 5'sd3;
            if (b[3]) w = w - 5'sd1;
            if (b[1]) w = w + 5'sd1;
            if (b[0]) w = w + 5'sd3;
            return w;
        end
    endfunction

    // Influence: 1 for the centre sensor, 2 for each other one
    function automatic logic [INFL_W-1:0] sens_infl(input t_sens b);
        logic [INFL_W-1:0] n;
        begin
            n = '0;
            if (b[4]) n = n + 4'd2;
            if (b[3]) n = n + 4'd2;
            if (b[2]) n = n + 4'd1;
            if (b[1]) n = n + 4'd2;
            if (b[0]) n = n + 4'd2;
            return n;
        end
    endfunction

endpackage

@@ src/lfs_in_if.sv @@
`timescale 1ns / 1ps
// lfs_in_if: sensor request channel (valid/ready plus sensor payload).
// Depends on lfs_pkg.
interface lfs_in_if;
    logic                      valid;
    logic                      ready;
    logic [lfs_pkg::SENS_W-1:0] sensor_bits;
    logic                      slow_mode;

    modport source (output valid, output sensor_bits, output slow_mode, input ready);
    modport sink   (input valid, input sensor_bits, input slow_mode, output ready);
endinterface

@@ src/lfs_out_if.sv @@
`timescale 1ns / 1ps
// lfs_out_if: wheel speed result channel (valid/ready plus speeds and tracking state).
// Depends on lfs_pkg.
interface lfs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lfs_pkg::SPD_W-1:0]  left_speed;
    logic signed [lfs_pkg::SPD_W-1:0]  right_speed;
    logic [lfs_pkg::TRK_W-1:0]         track_state;

    modport source (output valid, output left_speed, output right_speed,
                    output track_state, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input track_state, output ready);
endinterface

@@ src/line_follow_steering.sv @@
`timescale 1ns / 1ps
// line_follow_steering: proportional line-following wheel speed controller, top level.
// Depends on lfs_pkg, lfs_in_if and lfs_out_if.

// One request is one 5-bit ground sensor reading (inverted when the line is white)
// and gives one result: left and right wheel speeds and the tracking state. The
// block handles one request at a time; i_in.ready is high only while it is idle.
// A request that sees the line, or arrives while already lost, takes two passes of
// a 12-step restoring divider by the influence (1..9), one for each wheel. A
// request that sees no line while centered first scans the history memory, one
// entry per cycle through its single read port. The history is a circular
// buffer; a fill count makes entries not yet written read as zero, so there is
// no clearing pass after reset. The result sits in an output register, so a new
// request is taken while the previous result waits on o_out.ready; the block
// then holds its next result until that register frees up. Config writes
// (kp, base speed, lost_threshold, line_is_white) take effect at once and are
// expected only while the block is idle.
module line_follow_steering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lfs_in_if.sink                               i_in,
    lfs_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUM    = 3'd1;  // issue history reads
    localparam logic [2:0] ST_DRAIN  = 3'd2;  // last read data accumulates
    localparam logic [2:0] ST_DECIDE = 3'd3;  // lost-line decision
    localparam logic [2:0] ST_PREP   = 3'd4;  // weight, influence, products
    localparam logic [2:0] ST_LOAD   = 3'd5;  // form dividend for one wheel
    localparam logic [2:0] ST_DIV    = 3'd6;  // restoring divide steps
    localparam logic [2:0] ST_OUT    = 3'd7;  // hand result to output register

    // Configuration
    logic [lfs_pkg::KP_W-1:0]   r_kp;
    logic [lfs_pkg::BASE_W-1:0] r_base;
    logic [lfs_pkg::THR_W-1:0]  r_thr;
    logic                       r_white;

    // Control
    logic [2:0]                   r_state;
    lfs_pkg::t_trk                r_trk;
    logic [lfs_pkg::HIST_AW-1:0]  r_wptr;
    logic [lfs_pkg::HIST_AW-1:0]  r_p;
    logic [lfs_pkg::FILL_W-1:0]   r_fill;
    logic [lfs_pkg::HIST_AW-1:0]  r_idx;
    logic                         r_rdv;
    logic                         r_side;
    logic [lfs_pkg::DCNT_W-1:0]   r_dcnt;
    logic                         r_ovalid;

    // Datapath
    lfs_pkg::t_sens               r_hist [lfs_pkg::HIST_DEPTH];
    lfs_pkg::t_sens               r_rd;
    lfs_pkg::t_sens               r_bits;
    logic                         r_slow;
    logic [lfs_pkg::FILL_W-1:0]   r_age;
    logic [lfs_pkg::SUM_W-1:0]    r_lsum;
    logic [lfs_pkg::SUM_W-1:0]    r_rsum;
    logic [lfs_pkg::BI_W-1:0]     r_bi;
    logic signed [lfs_pkg::STEER_W-1:0] r_steer;
    logic [lfs_pkg::INFL_W-1:0]   r_infl;
    logic [lfs_pkg::NUM_W-1:0]    r_quo;
    logic [lfs_pkg::INFL_W-1:0]   r_rem;
    logic                         r_neg;
    lfs_pkg::t_speed              r_left;
    lfs_pkg::t_speed              r_right;
    lfs_pkg::t_speed              r_oleft;
    lfs_pkg::t_speed              r_oright;
    lfs_pkg::t_trk                r_otrk;

    logic                         in_acc;
    lfs_pkg::t_sens               in_bits;
    logic [lfs_pkg::HIST_AW-1:0]  rd_addr;
    logic [lfs_pkg::HIST_AW:0]    wrap_addr;
    logic [lfs_pkg::BASE_W-1:0]   base_eff;
    logic signed [lfs_pkg::WGT_W-1:0] wgt;
    logic [lfs_pkg::INFL_W-1:0]   infl;
    logic signed [lfs_pkg::STEER_W-1:0] steer_c;
    logic signed [lfs_pkg::NUM_W:0] num;
    logic signed [lfs_pkg::NUM_W:0] num_mag;
    logic [lfs_pkg::INFL_W:0]     trial;
    logic                         q_bit;
    logic [lfs_pkg::NUM_W-1:0]    n_quo;
    logic signed [lfs_pkg::NUM_W:0] q_signed;
    logic signed [lfs_pkg::NUM_W:0] q_res;
    logic                         l_over;
    logic                         r_over;
    logic                         out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_bits  = r_white ? ~i_in.sensor_bits : i_in.sensor_bits;
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.left_speed  = r_oleft;
    assign o_out.right_speed = r_oright;
    assign o_out.track_state = r_otrk;

    // History index i lives at address (newest - i) mod depth
    assign wrap_addr = {1'b0, r_p} + (lfs_pkg::HIST_AW + 1)'(lfs_pkg::HIST_DEPTH)
                       - {1'b0, r_idx};
    assign rd_addr   = (r_p >= r_idx) ? (r_p - r_idx) : wrap_addr[lfs_pkg::HIST_AW-1:0];

    assign l_over = lfs_pkg::CMP_W'(r_lsum) > lfs_pkg::CMP_W'(r_thr);
    assign r_over = lfs_pkg::CMP_W'(r_rsum) > lfs_pkg::CMP_W'(r_thr);

    // Steering weight and influence
    always_comb begin
        base_eff = r_slow ? (r_base >> 1) : r_base;
        if (r_bits != '0) begin
            wgt  = lfs_pkg::sens_weight(r_bits);
            infl = lfs_pkg::sens_infl(r_bits);
        end else if (r_trk == lfs_pkg::TRK_LOST_RIGHT) begin
            wgt  = lfs_pkg::LOST_WGT;
            infl = lfs_pkg::LOST_INFL;
        end else if (r_trk == lfs_pkg::TRK_LOST_LEFT) begin
            wgt  = -lfs_pkg::LOST_WGT;
            infl = lfs_pkg::LOST_INFL;
        end else begin
            wgt  = '0;
            infl = '0;
        end
        steer_c = lfs_pkg::STEER_W'($signed({1'b0, r_kp, 1'b0}))
                  * lfs_pkg::STEER_W'(wgt);
    end

    // Dividend for the current wheel, split into sign and magnitude
    always_comb begin
        if (r_side) begin
            num = $signed({2'b00, r_bi}) - (lfs_pkg::NUM_W + 1)'(r_steer);
        end else begin
            num = $signed({2'b00, r_bi}) + (lfs_pkg::NUM_W + 1)'(r_steer);
        end
        num_mag = num[lfs_pkg::NUM_W] ? -num : num;
    end

    // One restoring divide step
    always_comb begin
        trial    = {r_rem, r_quo[lfs_pkg::NUM_W-1]};
        q_bit    = (trial >= {1'b0, r_infl});
        n_quo    = {r_quo[lfs_pkg::NUM_W-2:0], q_bit};
        q_signed = $signed({1'b0, n_quo});
        q_res    = r_neg ? -q_signed : q_signed;
    end

    // History memory
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[r_wptr] <= in_bits;
        end
        r_rd <= r_hist[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= lfs_pkg::KP_RST;
            r_base  <= lfs_pkg::BASE_RST;
            r_thr   <= lfs_pkg::THR_RST;
            r_white <= lfs_pkg::WHITE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfs_pkg::CFG_KP:    r_kp    <= i_cfg_data[lfs_pkg::KP_W-1:0];
                lfs_pkg::CFG_BASE:  r_base  <= i_cfg_data[lfs_pkg::BASE_W-1:0];
                lfs_pkg::CFG_THR:   r_thr   <= i_cfg_data[lfs_pkg::THR_W-1:0];
                lfs_pkg::CFG_WHITE: r_white <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Age-weighted sums of the outer sensors, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lsum <= '0;
            r_rsum <= '0;
        end else if (r_rdv) begin
            if (r_rd[lfs_pkg::SENS_W-1]) r_lsum <= r_lsum + lfs_pkg::SUM_W'(r_age);
            if (r_rd[0])                 r_rsum <= r_rsum + lfs_pkg::SUM_W'(r_age);
        end
        r_age <= lfs_pkg::FILL_W'(lfs_pkg::HIST_DEPTH) - lfs_pkg::FILL_W'(r_idx);
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_trk    <= lfs_pkg::TRK_CENTERED;
            r_wptr   <= '0;
            r_fill   <= '0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_side   <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            // newest entry holds no line, so the scan starts at index 1
            r_rdv <= (r_state == ST_SUM) && (lfs_pkg::FILL_W'(r_idx) < r_fill);
            // ST_OUT reloads the output register itself
            if (r_ovalid && o_out.ready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_bits <= in_bits;
                        r_slow <= i_in.slow_mode;
                        r_p    <= r_wptr;
                        r_wptr <= (r_wptr == lfs_pkg::HIST_AW'(lfs_pkg::HIST_DEPTH - 1))
                                  ? '0 : r_wptr + 1'b1;
                        if (r_fill != lfs_pkg::FILL_W'(lfs_pkg::HIST_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_idx <= lfs_pkg::HIST_AW'(1);
                        if (in_bits != '0) begin
                            r_trk   <= lfs_pkg::TRK_CENTERED;
                            r_state <= ST_PREP;
                        end else if (r_trk == lfs_pkg::TRK_CENTERED) begin
                            r_state <= ST_SUM;
                        end else begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_SUM: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == lfs_pkg::HIST_AW'(lfs_pkg::HIST_DEPTH - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (l_over || r_over) begin
                        r_trk <= (r_lsum > r_rsum) ? lfs_pkg::TRK_LOST_LEFT
                                                   : lfs_pkg::TRK_LOST_RIGHT;
                    end
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_bi    <= lfs_pkg::BI_W'(base_eff) * lfs_pkg::BI_W'(infl);
                    r_steer <= steer_c;
                    r_infl  <= infl;
                    r_side  <= 1'b0;
                    if (infl == '0) begin
                        // no steering term: both wheels at base speed
                        r_left  <= lfs_pkg::t_speed'({1'b0, base_eff});
                        r_right <= lfs_pkg::t_speed'({1'b0, base_eff});
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_neg   <= num[lfs_pkg::NUM_W];
                    r_quo   <= num_mag[lfs_pkg::NUM_W-1:0];
                    r_rem   <= '0;
                    r_dcnt  <= lfs_pkg::DCNT_W'(lfs_pkg::NUM_W);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_quo  <= n_quo;
                    r_rem  <= q_bit ? lfs_pkg::INFL_W'(trial - {1'b0, r_infl})
                                    : trial[lfs_pkg::INFL_W-1:0];
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == lfs_pkg::DCNT_W'(1)) begin
                        if (r_side) begin
                            r_right <= q_res[lfs_pkg::SPD_W-1:0];
                            r_state <= ST_OUT;
                        end else begin
                            r_left  <= q_res[lfs_pkg::SPD_W-1:0];
                            r_side  <= 1'b1;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_oleft  <= r_left;
                        r_oright <= r_right;
                        r_otrk   <= r_trk;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a request that sees the line recenters tracking
    a_recenter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_bits != '0) |=> (r_trk == lfs_pkg::TRK_CENTERED))
        else $error("tracking not centered after line seen");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lfs_pkg::FILL_W'(lfs_pkg::HIST_DEPTH))
        else $error("history fill count past depth");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !in_acc) |=> (r_state == ST_IDLE))
        else $error("sequencer left idle without a request");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_LOAD) |-> (r_infl != '0))
        else $error("divide by zero influence");
`endif

endmodule
